@@ rtl/spt_pkg.sv @@
package spt_pkg;

  // field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TALLY_W = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ADDR_W  = 4;

  // result queue depth (records, each holding up to two results)
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  // register indexes
  typedef enum logic [1:0] {
    REG_GAP      = 2'd0,
    REG_WINDOW   = 2'd1,
    REG_REQUIRED = 2'd2,
    REG_NONE     = 2'd3
  } spt_reg_t;

  // configuration as seen by the front end
  typedef struct packed {
    logic [TIME_W-1:0]  gap_ticks;
    logic [TIME_W-1:0]  window_ticks;
    logic [TALLY_W-1:0] required_pulses;
  } spt_cfg_t;

  // results of one input item: first result, optional second result
  typedef struct packed {
    logic              two;
    logic [TIME_W-1:0] start0;
    logic [TIME_W-1:0] start1;
  } spt_rec_t;

endpackage

@@ rtl/spt_if.sv @@
// input channel: pulse timestamps
interface spt_in_if;
  import spt_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] pulse_time;
  logic              final_pulse;

  modport source (output valid, output pulse_time, output final_pulse, input ready);
  modport sink   (input valid, input pulse_time, input final_pulse, output ready);
endinterface

// result channel: start times of valid trains
interface spt_out_if;
  import spt_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] train_start;
  logic              last_of_run;

  modport source (output valid, output train_start, output last_of_run, input ready);
  modport sink   (input valid, input train_start, input last_of_run, output ready);
endinterface

@@ rtl/spt_regs.sv @@
module spt_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spt_pkg::ADDR_W-1:0]  paddr,
  input  logic [spt_pkg::DATA_W-1:0]  pwdata,
  output logic [spt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output spt_pkg::spt_cfg_t           cfg
);
  import spt_pkg::*;

  spt_cfg_t cfg_r, cfg_nxt;
  spt_reg_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = spt_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        REG_GAP:      cfg_nxt.gap_ticks       = pwdata[TIME_W-1:0];
        REG_WINDOW:   cfg_nxt.window_ticks    = pwdata[TIME_W-1:0];
        REG_REQUIRED: cfg_nxt.required_pulses = pwdata[TALLY_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gap_ticks       <= '0;
      cfg_r.window_ticks    <= '0;
      cfg_r.required_pulses <= TALLY_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_sel)
      REG_GAP:      prdata = DATA_W'(cfg_r.gap_ticks);
      REG_WINDOW:   prdata = DATA_W'(cfg_r.window_ticks);
      REG_REQUIRED: prdata = DATA_W'(cfg_r.required_pulses);
      default:      prdata = '0;
    endcase
  end
endmodule

@@ rtl/spt_front.sv @@
module spt_front (
  input  logic              clk,
  input  logic              rst_n,
  spt_in_if.sink            in_ch,
  input  spt_pkg::spt_cfg_t cfg,
  input  logic              q_full,
  output logic              q_push,
  output spt_pkg::spt_rec_t q_rec
);
  import spt_pkg::*;

  logic               train_open_r, train_open_nxt;
  logic               first_seen_r, first_seen_nxt;
  logic [TIME_W-1:0]  prev_r;
  logic [TIME_W-1:0]  first_r, first_nxt;
  logic [TIME_W-1:0]  member_r, member_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;

  logic              acc;
  logic [TIME_W-1:0] t;
  logic [TIME_W-1:0] since_first, since_member, since_ref, ref_time;
  logic              in_window, close_emit, qualifies, open_after, final_emit;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;
  assign t           = in_ch.pulse_time;

  // differences modulo 2^32
  assign since_first  = t - first_r;
  assign since_member = t - member_r;
  assign ref_time     = train_open_r ? member_r : prev_r;
  assign since_ref    = t - ref_time;

  // classify the word against the open train
  assign in_window  = train_open_r && (since_first < cfg.window_ticks);
  assign close_emit = train_open_r && !in_window &&
                      (since_member >= cfg.gap_ticks) &&
                      (tally_r == cfg.required_pulses);
  assign qualifies  = !in_window && (!first_seen_r || (since_ref >= cfg.gap_ticks));

  // train state after this word, before the final mark
  always_comb begin
    first_nxt  = first_r;
    member_nxt = member_r;
    tally_nxt  = tally_r;
    if (in_window) begin
      member_nxt = t;
      if (tally_r != TALLY_MAX) tally_nxt = tally_r + TALLY_W'(1);
    end else if (qualifies) begin
      first_nxt  = t;
      member_nxt = t;
      tally_nxt  = TALLY_W'(1);
    end
  end

  assign open_after = in_window || qualifies;
  assign final_emit = in_ch.final_pulse && open_after &&
                      (tally_nxt == cfg.required_pulses);

  always_comb begin
    train_open_nxt = open_after && !in_ch.final_pulse;
    first_seen_nxt = !in_ch.final_pulse;
  end

  // result record for the queue
  always_comb begin
    q_push = acc && (close_emit || final_emit);
    if (close_emit) begin
      q_rec.two    = final_emit;
      q_rec.start0 = first_r;
      q_rec.start1 = first_nxt;
    end else begin
      q_rec.two    = 1'b0;
      q_rec.start0 = first_nxt;
      q_rec.start1 = first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      train_open_r <= 1'b0;
      first_seen_r <= 1'b0;
      prev_r       <= '0;
      first_r      <= '0;
      member_r     <= '0;
      tally_r      <= '0;
    end else if (acc) begin
      train_open_r <= train_open_nxt;
      first_seen_r <= first_seen_nxt;
      prev_r       <= t;
      first_r      <= first_nxt;
      member_r     <= member_nxt;
      tally_r      <= tally_nxt;
    end
  end
endmodule

@@ rtl/spt_queue.sv @@
module spt_queue #(
  parameter int unsigned DEPTH = spt_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spt_pkg::spt_rec_t push_rec,
  input  logic              pop,
  output spt_pkg::spt_rec_t head_rec,
  output logic              empty,
  output logic              full
);
  import spt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  spt_rec_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_rec = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    if (do_push && !do_pop)      count_nxt = count_r + CNT_W'(1);
    else if (!do_push && do_pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end
endmodule

@@ rtl/spt_back.sv @@
module spt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  spt_pkg::spt_rec_t head_rec,
  input  logic              q_empty,
  output logic              q_pop,
  spt_out_if.source         out_ch
);
  import spt_pkg::*;

  spt_rec_t rec_r;
  logic     hold_r, hold_nxt;
  logic     phase_r, phase_nxt;
  logic     fire, done;

  assign fire  = hold_r && out_ch.ready;
  assign done  = fire && (!rec_r.two || phase_r);
  assign q_pop = !q_empty && (!hold_r || done);

  // output word from the held record
  assign out_ch.valid       = hold_r;
  assign out_ch.train_start = phase_r ? rec_r.start1 : rec_r.start0;
  assign out_ch.last_of_run = !rec_r.two || phase_r;

  // hold and phase control
  always_comb begin
    hold_nxt  = hold_r;
    phase_nxt = phase_r;
    if (q_pop) begin
      hold_nxt  = 1'b1;
      phase_nxt = 1'b0;
    end else if (done) begin
      hold_nxt  = 1'b0;
      phase_nxt = 1'b0;
    end else if (fire) begin
      phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) rec_r <= head_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      hold_r  <= hold_nxt;
      phase_r <= phase_nxt;
    end
  end
endmodule

@@ rtl/sync_pulse_train_detector.sv @@
// Sync pulse train detector.
// in_ch carries one pulse word per handshake: pulse_time (ticks, nondecreasing)
// and final_pulse marking the last pulse of a data set. out_ch carries one
// word per valid train: train_start and last_of_run, set on the last result
// that an input word causes (each input gives zero, one or two results).
// Registers over the APB port: 0x0 gap_ticks, 0x4 window_ticks,
// 0x8 required_pulses; write them only while the block is idle.
// Throughput: one pulse word per cycle while the queue is not full; the front
// end classifies each word combinationally with three subtract-compares and
// the tally update. An input causing two results gives two output words.
// A result passes the result queue write, then the output register load,
// before it is presented on out_ch.
// A queue of QUEUE_DEPTH records between front and back end lets the input
// keep flowing while out_ch stalls; in_ch.ready drops once the queue is full.
// Reset (synchronous, rst_n low) closes any train, starts a new data set and
// restores the register defaults (gap 0, window 0, required 1).
module sync_pulse_train_detector #(
  parameter int unsigned QUEUE_DEPTH = spt_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  spt_in_if.sink                     in_ch,
  spt_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spt_pkg::ADDR_W-1:0] paddr,
  input  logic [spt_pkg::DATA_W-1:0] pwdata,
  output logic [spt_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import spt_pkg::*;

  spt_cfg_t cfg;
  spt_rec_t push_rec, head_rec;
  logic     q_push, q_pop, q_empty, q_full;

  // configuration registers
  spt_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // classify pulses and track the open train
  spt_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_rec  (push_rec)
  );

  // result records between front and back end
  spt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .head_rec (head_rec),
    .empty    (q_empty),
    .full     (q_full)
  );

  // unpack records onto the output channel
  spt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_rec (head_rec),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );
endmodule
